// ===== rtl/core/assoc_upper_layer_fsm_macros.svh =====
// Assertion macros for the association-control state machine checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef ASSOC_UPPER_LAYER_FSM_MACROS_SVH
`define ASSOC_UPPER_LAYER_FSM_MACROS_SVH

// Antecedent holds in a cycle, so the consequent must hold in the same cycle.
`define AULF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aulf checker: same-cycle implication failed");

// Antecedent holds in a cycle, so the consequent must hold in the next cycle.
`define AULF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aulf checker: next-cycle implication failed");

`endif

// ===== rtl/core/aulf_pkg.sv =====
// Shared types, codes and the transition table for the association-control FSM.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package aulf_pkg;

    // Event and state widths and counts.
    localparam int EV_W    = 5;
    localparam int ST_W    = 4;
    localparam int NUM_EV  = 19;
    localparam int NUM_ST  = 13;

    // Decoupling queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Connection states.
    localparam logic [ST_W-1:0] ST_IDLE = 4'd1;
    localparam logic [ST_W-1:0] ST_LAST = 4'd13;

    // Next-state codes used by the action table, and the two collision states.
    localparam logic [ST_W-1:0] NXT_KEEP = 4'd0;
    localparam logic [ST_W-1:0] NXT_ROLE = 4'd15;
    localparam logic [ST_W-1:0] ST_COLL_REQ = 4'd9;
    localparam logic [ST_W-1:0] ST_COLL_ACC = 4'd10;

    typedef logic [4:0] t_aid;

    // Action identifiers.
    localparam t_aid NA  = 5'd0;
    localparam t_aid A1  = 5'd1;
    localparam t_aid A2  = 5'd2;
    localparam t_aid A3  = 5'd3;
    localparam t_aid A4  = 5'd4;
    localparam t_aid A5  = 5'd5;
    localparam t_aid A6  = 5'd6;
    localparam t_aid A7  = 5'd7;
    localparam t_aid A8  = 5'd8;
    localparam t_aid E1  = 5'd9;
    localparam t_aid E2  = 5'd10;
    localparam t_aid E3  = 5'd11;
    localparam t_aid E4  = 5'd12;
    localparam t_aid E5  = 5'd13;
    localparam t_aid E6  = 5'd14;
    localparam t_aid E7  = 5'd15;
    localparam t_aid E8  = 5'd16;
    localparam t_aid R1  = 5'd17;
    localparam t_aid R2  = 5'd18;
    localparam t_aid R3  = 5'd19;
    localparam t_aid R4  = 5'd20;
    localparam t_aid R5  = 5'd21;
    localparam t_aid R6  = 5'd22;
    localparam t_aid R7  = 5'd23;
    localparam t_aid R8  = 5'd24;
    localparam t_aid R9  = 5'd25;
    localparam t_aid R10 = 5'd26;
    localparam t_aid DK  = 5'd27;

    typedef struct packed {
        logic abort;
        logic start;
        logic stop;
        logic close;
        logic skip;
    } t_flags;

    typedef struct packed {
        logic [ST_W-1:0] nxt;
        t_flags          fl;
    } t_act;

    // One classified event as it travels from front to back.
    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic            known;
    } t_item;

    // Rows are events 0..18, columns are states 1..13.
    localparam t_aid TRANS [0:NUM_EV-1][0:NUM_ST-1] = '{
        '{E1, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
        '{NA, NA, NA, E2, NA, NA, NA, NA, NA, NA, NA, NA, NA},
        '{NA, A1, A8, NA, E3, A8, A8, A8, A8, A8, A8, A8, A6},
        '{NA, A1, A8, NA, E4, A8, A8, A8, A8, A8, A8, A8, A6},
        '{E5, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
        '{NA, E6, A8, NA, A8, A8, A8, A8, A8, A8, A8, A8, A7},
        '{NA, NA, E7, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
        '{NA, NA, E8, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
        '{NA, NA, NA, NA, NA, DK, NA, R7, NA, NA, NA, NA, NA},
        '{NA, A1, A8, NA, A8, DK, R6, A8, A8, A8, A8, A8, A6},
        '{NA, NA, NA, NA, NA, R1, NA, NA, NA, NA, NA, NA, NA},
        '{NA, A1, A8, NA, A8, R2, R8, A8, A8, A8, A8, A8, A6},
        '{NA, A1, A8, NA, A8, A8, R3, A8, A8, R10, R3, A8, A6},
        '{NA, NA, NA, NA, NA, NA, NA, R4, R9, NA, NA, R4, NA},
        '{NA, NA, A1, A2, A1, A1, A1, A1, A1, A1, A1, A1, NA},
        '{NA, A2, A3, NA, A3, A3, A3, A3, A3, A3, A3, A3, A2},
        '{NA, A5, A4, A4, A4, A4, A4, A4, A4, A4, A4, A4, R5},
        '{NA, A2, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, A2},
        '{NA, A1, A8, NA, A8, A8, A8, A8, A8, A8, A8, A8, A7}
    };

    // Next state and strobes of one action. Actions that keep the state
    // (including the no-action code) fall to the default arm.
    function automatic t_act f_act(input t_aid aid);
        t_act a;
        a = '{nxt: NXT_KEEP, fl: '0};
        unique case (aid)
            A1:      a = '{nxt: 4'd13, fl: '{abort: 1'b1, start: 1'b1, default: 1'b0}};
            A2:      a = '{nxt: 4'd1,  fl: '{stop: 1'b1, close: 1'b1, default: 1'b0}};
            A3:      a = '{nxt: 4'd1,  fl: '{close: 1'b1, default: 1'b0}};
            A4:      a = '{nxt: 4'd1,  fl: '{stop: 1'b1, default: 1'b0}};
            A5:      a = '{nxt: 4'd1,  fl: '{stop: 1'b1, default: 1'b0}};
            A6:      a = '{nxt: 4'd13, fl: '{skip: 1'b1, default: 1'b0}};
            A7:      a = '{nxt: 4'd13, fl: '{abort: 1'b1, default: 1'b0}};
            A8:      a = '{nxt: 4'd13, fl: '{abort: 1'b1, start: 1'b1, default: 1'b0}};
            E1:      a = '{nxt: 4'd4,  fl: '0};
            E2:      a = '{nxt: 4'd5,  fl: '0};
            E3:      a = '{nxt: 4'd6,  fl: '0};
            E4:      a = '{nxt: 4'd1,  fl: '{close: 1'b1, default: 1'b0}};
            E5:      a = '{nxt: 4'd2,  fl: '{start: 1'b1, default: 1'b0}};
            E6:      a = '{nxt: 4'd3,  fl: '{stop: 1'b1, default: 1'b0}};
            E7:      a = '{nxt: 4'd6,  fl: '0};
            E8:      a = '{nxt: 4'd13, fl: '{start: 1'b1, default: 1'b0}};
            R1:      a = '{nxt: 4'd7,  fl: '0};
            R2:      a = '{nxt: 4'd8,  fl: '0};
            R3:      a = '{nxt: 4'd1,  fl: '{close: 1'b1, default: 1'b0}};
            R4:      a = '{nxt: 4'd13, fl: '{start: 1'b1, default: 1'b0}};
            R5:      a = '{nxt: 4'd1,  fl: '{stop: 1'b1, default: 1'b0}};
            R7:      a = '{nxt: 4'd8,  fl: '0};
            R8:      a = '{nxt: NXT_ROLE, fl: '0};
            R9:      a = '{nxt: 4'd11, fl: '0};
            R10:     a = '{nxt: 4'd12, fl: '0};
            default: a = '{nxt: NXT_KEEP, fl: '0};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aulf_front.sv =====
// Front stage: takes event beats and classifies the event code.
// Depends on aulf_pkg.
`default_nettype none

module aulf_front
    import aulf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [EV_W-1:0] i_event_code,
    output logic                 o_valid,
    output t_item                o_item,
    input  wire logic            i_full
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_take;
    logic  w_push;

    // The held beat leaves whenever the queue has room.
    assign w_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (w_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Codes beyond the last event never match the table.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.ev    <= i_event_code;
            r_item.known <= (i_event_code < EV_W'(NUM_EV));
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/aulf_queue.sv =====
// Short queue that decouples the front stage from the back stage.
// Depends on aulf_pkg (item type and depth).
`default_nettype none

module aulf_queue
    import aulf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_item  i_item,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_pop,
    output t_item       o_item
);

    t_item              r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aulf_back.sv =====
// Back stage: table lookup, connection-state update and the result register.
// Depends on aulf_pkg (transition table, action decode, types).
`default_nettype none

module aulf_back
    import aulf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    input  wire logic            i_valid,
    output logic                 o_pop,
    input  wire t_item           i_item,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic [ST_W-1:0]      o_conn_state_now,
    output logic                 o_invalid_event,
    output t_flags               o_flags
);

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;
    logic            r_role;
    logic            r_out_valid;
    logic [ST_W-1:0] r_out_state;
    logic            r_out_invalid;
    t_flags          r_out_flags;
    logic            w_st_ok;
    logic [ST_W-1:0] w_col;
    t_aid            w_aid;
    t_act            w_act;
    logic            w_invalid;

    assign o_pop   = i_valid && (!r_out_valid || !i_stall);
    assign w_st_ok = (r_state >= ST_IDLE) && (r_state <= ST_LAST);
    assign w_col   = r_state - ST_IDLE;

    always_comb begin
        w_aid = NA;
        if (i_item.known && w_st_ok) begin
            w_aid = TRANS[i_item.ev][w_col];
        end
    end

    assign w_act     = f_act(w_aid);
    assign w_invalid = (w_aid == NA);

    always_comb begin
        n_state = r_state;
        if (!w_invalid) begin
            priority if (w_act.nxt == NXT_ROLE) begin
                n_state = r_role ? ST_COLL_REQ : ST_COLL_ACC;
            end else if (w_act.nxt != NXT_KEEP) begin
                n_state = w_act.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_role      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_role <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_state   <= n_state;
            r_out_invalid <= w_invalid;
            r_out_flags   <= w_act.fl;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_conn_state_now = r_out_state;
    assign o_invalid_event  = r_out_invalid;
    assign o_flags          = r_out_flags;

endmodule

`default_nettype wire

// ===== rtl/core/assoc_upper_layer_fsm.sv =====
// Association-control state machine of the upper protocol layer.
// Event beats enter on one valid/stall channel and each yields one result beat
// carrying the new connection state and the action strobes for that event.
// The block holds thirteen connection states and resets to state 1 (idle);
// the role register resets to requestor.
// An accepted event passes through the front register, the two-entry queue
// and the result register. Throughput is one event per cycle while i_out_stall
// is low; the single table lookup and state update in the back stage sets
// that figure. Synchronous active-low reset initialises all control state.
// When the receiver raises i_out_stall the result register holds its beat,
// the queue fills, and only then does o_in_stall rise; an event is accepted
// when i_in_valid is high and o_in_stall is low.
// The role register is written by i_cfg_we with no wait; the user must write
// it only while no event is in flight, as the block does not enforce this.
// Depends on aulf_pkg, aulf_front, aulf_queue and aulf_back.
`default_nettype none

module assoc_upper_layer_fsm
    import aulf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [EV_W-1:0] i_event_code,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [ST_W-1:0]      o_conn_state_now,
    output logic                 o_invalid_event,
    output logic                 o_send_abort,
    output logic                 o_timer_start,
    output logic                 o_timer_stop,
    output logic                 o_close_transport,
    output logic                 o_skip_next_pdu
);

    // Front to queue.
    logic   w_fr_valid;
    t_item  w_fr_item;
    logic   w_q_full;

    // Queue to back.
    logic   w_q_valid;
    t_item  w_q_item;
    logic   w_pop;

    t_flags w_flags;

    // The front stage registers each beat and flags event codes that lie
    // beyond the table, so the back stage only has to index it.
    aulf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_event_code (i_event_code),
        .o_valid      (w_fr_valid),
        .o_item       (w_fr_item),
        .i_full       (w_q_full)
    );

    // The queue lets the front keep taking beats while a result waits.
    aulf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .i_item  (w_fr_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    // The back stage owns the connection state and the role register. It
    // pops an event only when its result register is free or being drained.
    aulf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (w_q_valid),
        .o_pop            (w_pop),
        .i_item           (w_q_item),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_conn_state_now (o_conn_state_now),
        .o_invalid_event  (o_invalid_event),
        .o_flags          (w_flags)
    );

    assign o_send_abort      = w_flags.abort;
    assign o_timer_start     = w_flags.start;
    assign o_timer_stop      = w_flags.stop;
    assign o_close_transport = w_flags.close;
    assign o_skip_next_pdu   = w_flags.skip;

endmodule

`default_nettype wire

// ===== rtl/core/aulf_checker.sv =====
// Port-level checker for the association-control FSM, bound to the top level.
// Depends on aulf_pkg and the assertion macros header.
`default_nettype none
`include "assoc_upper_layer_fsm_macros.svh"

module aulf_checker
    import aulf_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_cfg_we,
    input wire logic            i_cfg_wdata,
    input wire logic            i_in_valid,
    input wire logic            o_in_stall,
    input wire logic [EV_W-1:0] i_event_code,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire logic [ST_W-1:0] o_conn_state_now,
    input wire logic            o_invalid_event,
    input wire logic            o_send_abort,
    input wire logic            o_timer_start,
    input wire logic            o_timer_stop,
    input wire logic            o_close_transport,
    input wire logic            o_skip_next_pdu
);

    logic w_any_strobe;

    assign w_any_strobe = o_send_abort || o_timer_start || o_timer_stop
                       || o_close_transport || o_skip_next_pdu;

    // A stalled result beat is not withdrawn.
    `AULF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // The reported state is always one of the thirteen connection states.
    `AULF_ASSERT_IMP(a_state_range, i_clk, i_rst_n, o_out_valid, (o_conn_state_now >= ST_IDLE) && (o_conn_state_now <= ST_LAST))

    // A rejected event carries no action.
    `AULF_ASSERT_IMP(a_invalid_quiet, i_clk, i_rst_n, o_out_valid && o_invalid_event, !w_any_strobe)

    // The timer is never started and stopped by the same event.
    `AULF_ASSERT_IMP(a_timer_excl, i_clk, i_rst_n, o_out_valid, !(o_timer_start && o_timer_stop))

endmodule

bind assoc_upper_layer_fsm aulf_checker u_aulf_checker (.*);

`default_nettype wire

// ===== bench/assoc_upper_layer_fsm_tb.sv =====
// Self-checking testbench for the association-control state machine.
// Depends on aulf_pkg for the port widths and on the assoc_upper_layer_fsm RTL.
// Needs nothing else: stimulus, prediction and checking all live in this file.
`default_nettype none

module assoc_upper_layer_fsm_tb;

    import aulf_pkg::EV_W;
    import aulf_pkg::ST_W;

    // ------------------------------------------------------------------
    // Protocol events, in the block's numbering.
    // ------------------------------------------------------------------
    localparam logic [EV_W-1:0] EV_LOCAL_ASSOC_RQ   = 5'd0;
    localparam logic [EV_W-1:0] EV_TRANSPORT_CONF   = 5'd1;
    localparam logic [EV_W-1:0] EV_ASSOC_AC_PDU     = 5'd2;
    localparam logic [EV_W-1:0] EV_ASSOC_RJ_PDU     = 5'd3;
    localparam logic [EV_W-1:0] EV_TRANSPORT_IND    = 5'd4;
    localparam logic [EV_W-1:0] EV_ASSOC_RQ_PDU     = 5'd5;
    localparam logic [EV_W-1:0] EV_LOCAL_ASSOC_AC   = 5'd6;
    localparam logic [EV_W-1:0] EV_LOCAL_ASSOC_RJ   = 5'd7;
    localparam logic [EV_W-1:0] EV_LOCAL_DATA       = 5'd8;
    localparam logic [EV_W-1:0] EV_DATA_PDU         = 5'd9;
    localparam logic [EV_W-1:0] EV_LOCAL_REL_RQ     = 5'd10;
    localparam logic [EV_W-1:0] EV_REL_RQ_PDU       = 5'd11;
    localparam logic [EV_W-1:0] EV_REL_RP_PDU       = 5'd12;
    localparam logic [EV_W-1:0] EV_LOCAL_REL_RP     = 5'd13;
    localparam logic [EV_W-1:0] EV_LOCAL_ABORT      = 5'd14;
    localparam logic [EV_W-1:0] EV_ABORT_PDU        = 5'd15;
    localparam logic [EV_W-1:0] EV_TRANSPORT_CLOSED = 5'd16;
    localparam logic [EV_W-1:0] EV_TIMER_EXPIRED    = 5'd17;
    localparam logic [EV_W-1:0] EV_BAD_PDU          = 5'd18;
    localparam logic [EV_W-1:0] EV_LAST             = EV_BAD_PDU;
    localparam logic [EV_W-1:0] EV_CODE_MAX         = 5'd31;

    // Connection states, named after the protocol's Sta1..Sta13.
    localparam logic [ST_W-1:0] STA1  = 4'd1;
    localparam logic [ST_W-1:0] STA2  = 4'd2;
    localparam logic [ST_W-1:0] STA3  = 4'd3;
    localparam logic [ST_W-1:0] STA4  = 4'd4;
    localparam logic [ST_W-1:0] STA5  = 4'd5;
    localparam logic [ST_W-1:0] STA6  = 4'd6;
    localparam logic [ST_W-1:0] STA7  = 4'd7;
    localparam logic [ST_W-1:0] STA8  = 4'd8;
    localparam logic [ST_W-1:0] STA9  = 4'd9;
    localparam logic [ST_W-1:0] STA10 = 4'd10;
    localparam logic [ST_W-1:0] STA11 = 4'd11;
    localparam logic [ST_W-1:0] STA12 = 4'd12;
    localparam logic [ST_W-1:0] STA13 = 4'd13;

    // Values of the role register.
    localparam logic RL_ACCEPTOR  = 1'b0;
    localparam logic RL_REQUESTOR = 1'b1;

    // Run shape. The cycle limit is far above the slowest legal run: every
    // beat waiting out the longest sender gap and the longest receiver stall,
    // plus the two long receiver hold-offs and the drains between phases.
    localparam int N_DIRECTED      = 25;
    localparam int ITEMS_PER_PHASE = 356;
    localparam int N_PHASES        = 4;
    localparam int HOLDOFF_CYCLES  = 150;
    localparam int DRAIN_TAIL      = 8;
    localparam int CYCLE_LIMIT     = 600000;

    // ------------------------------------------------------------------
    // Predictor: the transition table and the effect of each action.
    // ILL marks a pair that the protocol does not allow. AR6 and DT keep
    // the state and raise nothing.
    // ------------------------------------------------------------------
    typedef enum logic [4:0] {
        ILL,
        AA1, AA2, AA3, AA4, AA5, AA6, AA7, AA8,
        AE1, AE2, AE3, AE4, AE5, AE6, AE7, AE8,
        AR1, AR2, AR3, AR4, AR5, AR6, AR7, AR8, AR9, AR10,
        DT
    } assoc_act_e;

    // Rows are events 0..18, columns are states 1..13.
    localparam assoc_act_e ACTION_MAP [0:18][1:13] = '{
        '{AE1, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, ILL, ILL, AE2, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, AA1, AA8, ILL, AE3, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA6},
        '{ILL, AA1, AA8, ILL, AE4, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA6},
        '{AE5, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, AE6, AA8, ILL, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA7},
        '{ILL, ILL, AE7, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, ILL, AE8, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, ILL, ILL, ILL, ILL, DT,  ILL, AR7, ILL, ILL, ILL, ILL, ILL},
        '{ILL, AA1, AA8, ILL, AA8, DT,  AR6, AA8, AA8, AA8, AA8, AA8, AA6},
        '{ILL, ILL, ILL, ILL, ILL, AR1, ILL, ILL, ILL, ILL, ILL, ILL, ILL},
        '{ILL, AA1, AA8, ILL, AA8, AR2, AR8, AA8, AA8, AA8, AA8, AA8, AA6},
        '{ILL, AA1, AA8, ILL, AA8, AA8, AR3, AA8, AA8, AR10, AR3, AA8, AA6},
        '{ILL, ILL, ILL, ILL, ILL, ILL, ILL, AR4, AR9, ILL, ILL, AR4, ILL},
        '{ILL, ILL, AA1, AA2, AA1, AA1, AA1, AA1, AA1, AA1, AA1, AA1, ILL},
        '{ILL, AA2, AA3, ILL, AA3, AA3, AA3, AA3, AA3, AA3, AA3, AA3, AA2},
        '{ILL, AA5, AA4, AA4, AA4, AA4, AA4, AA4, AA4, AA4, AA4, AA4, AR5},
        '{ILL, AA2, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, ILL, AA2},
        '{ILL, AA1, AA8, ILL, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA8, AA7}
    };

    // One result beat as the block reports it.
    typedef struct packed {
        logic [ST_W-1:0] conn_state;
        logic            invalid_ev;
        logic            send_abort;
        logic            timer_start;
        logic            timer_stop;
        logic            close_tp;
        logic            skip_pdu;
    } assoc_result_t;

    // One row of the directed part. Rows with pinned set carry a result
    // typed in by hand; the rest are checked against the predictor.
    typedef struct packed {
        logic [EV_W-1:0] ev;
        logic            pinned;
        assoc_result_t   want;
    } directed_row_t;

    localparam assoc_result_t REJECT_AT_IDLE =
        '{conn_state: STA1, invalid_ev: 1'b1, default: 1'b0};
    localparam assoc_result_t OPEN_REQUESTED = '{conn_state: STA4, default: 1'b0};
    localparam assoc_result_t COLLIDE_AS_REQ = '{conn_state: STA9, default: 1'b0};
    localparam assoc_result_t NOT_PINNED     = '0;

    // The directed part walks one association through every event: junk
    // codes at idle, open as requestor, data, a release collision, the
    // acceptor path with the lenient associate-request, the local reject,
    // every abort flavor and the timer expiry.
    localparam directed_row_t DIRECTED [0:N_DIRECTED-1] = '{
        '{EV_CODE_MAX,         1'b1, REJECT_AT_IDLE},
        '{EV_LAST + 5'd1,      1'b1, REJECT_AT_IDLE},
        '{EV_ASSOC_AC_PDU,     1'b1, REJECT_AT_IDLE},
        '{EV_LOCAL_ASSOC_RQ,   1'b1, OPEN_REQUESTED},
        '{EV_TRANSPORT_CONF,   1'b0, NOT_PINNED},
        '{EV_ASSOC_AC_PDU,     1'b0, NOT_PINNED},
        '{EV_LOCAL_DATA,       1'b0, NOT_PINNED},
        '{EV_DATA_PDU,         1'b0, NOT_PINNED},
        '{EV_LOCAL_REL_RQ,     1'b0, NOT_PINNED},
        '{EV_REL_RQ_PDU,       1'b1, COLLIDE_AS_REQ},
        '{EV_LOCAL_REL_RP,     1'b0, NOT_PINNED},
        '{EV_REL_RP_PDU,       1'b0, NOT_PINNED},
        '{EV_TRANSPORT_IND,    1'b0, NOT_PINNED},
        '{EV_ASSOC_RQ_PDU,     1'b0, NOT_PINNED},
        '{EV_LOCAL_ASSOC_AC,   1'b0, NOT_PINNED},
        '{EV_LOCAL_ABORT,      1'b0, NOT_PINNED},
        '{EV_ASSOC_RJ_PDU,     1'b0, NOT_PINNED},
        '{EV_ASSOC_RQ_PDU,     1'b0, NOT_PINNED},
        '{EV_TRANSPORT_CLOSED, 1'b0, NOT_PINNED},
        '{EV_TRANSPORT_IND,    1'b0, NOT_PINNED},
        '{EV_BAD_PDU,          1'b0, NOT_PINNED},
        '{EV_ABORT_PDU,        1'b0, NOT_PINNED},
        '{EV_TRANSPORT_IND,    1'b0, NOT_PINNED},
        '{EV_TIMER_EXPIRED,    1'b0, NOT_PINNED},
        '{EV_LOCAL_ASSOC_RJ,   1'b1, REJECT_AT_IDLE}
    };

    // Works out the result of one event from the current state and the
    // role. A code above the last event, a pair outside the table and a
    // state outside 1..13 all give the invalid flag and keep the state.
    function automatic assoc_result_t assoc_step(input logic [ST_W-1:0] cur,
                                                 input logic role,
                                                 input logic [EV_W-1:0] ev);
        assoc_result_t r;
        assoc_act_e    act;
        r = '0;
        r.conn_state = cur;
        act = ILL;
        if (ev <= EV_LAST && cur >= STA1 && cur <= STA13) begin
            act = ACTION_MAP[ev][cur];
        end
        case (act)
            ILL:  r.invalid_ev = 1'b1;
            // Abort from the handshake also starts the timer.
            AA1, AA8: begin
                r.conn_state = STA13;
                r.send_abort = 1'b1;
                r.timer_start = 1'b1;
            end
            AA2: begin
                r.conn_state = STA1;
                r.timer_stop = 1'b1;
                r.close_tp = 1'b1;
            end
            AA3, AE4, AR3: begin
                r.conn_state = STA1;
                r.close_tp = 1'b1;
            end
            AA4, AA5, AR5: begin
                r.conn_state = STA1;
                r.timer_stop = 1'b1;
            end
            AA6: begin
                r.conn_state = STA13;
                r.skip_pdu = 1'b1;
            end
            AA7: begin
                r.conn_state = STA13;
                r.send_abort = 1'b1;
            end
            AE1:  r.conn_state = STA4;
            AE2:  r.conn_state = STA5;
            AE3, AE7: r.conn_state = STA6;
            AE5: begin
                r.conn_state = STA2;
                r.timer_start = 1'b1;
            end
            AE6: begin
                r.conn_state = STA3;
                r.timer_stop = 1'b1;
            end
            AE8, AR4: begin
                r.conn_state = STA13;
                r.timer_start = 1'b1;
            end
            AR1:  r.conn_state = STA7;
            AR2, AR7: r.conn_state = STA8;
            // Release collision: the requestor side waits in state 9.
            AR8:  r.conn_state = role ? STA9 : STA10;
            AR9:  r.conn_state = STA11;
            AR10: r.conn_state = STA12;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic            i_clk        = 1'b0;
    logic            i_rst_n      = 1'b0;
    logic            i_cfg_we     = 1'b0;
    logic            i_cfg_wdata  = 1'b0;
    logic            i_in_valid   = 1'b0;
    logic [EV_W-1:0] i_event_code = '0;
    logic            i_out_stall  = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic [ST_W-1:0] o_conn_state_now;
    logic            o_invalid_event;
    logic            o_send_abort;
    logic            o_timer_start;
    logic            o_timer_stop;
    logic            o_close_transport;
    logic            o_skip_next_pdu;

    always #1 i_clk = ~i_clk;

    assoc_upper_layer_fsm u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_event_code      (i_event_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_conn_state_now  (o_conn_state_now),
        .o_invalid_event   (o_invalid_event),
        .o_send_abort      (o_send_abort),
        .o_timer_start     (o_timer_start),
        .o_timer_stop      (o_timer_stop),
        .o_close_transport (o_close_transport),
        .o_skip_next_pdu   (o_skip_next_pdu)
    );

    // ------------------------------------------------------------------
    // Bench state shared by the processes.
    // ------------------------------------------------------------------
    // Pinned expectation that travels alongside the offered beat.
    logic          beat_pinned = 1'b0;
    assoc_result_t beat_want   = '0;

    // Receiver controls, written by the stimulus process with nonblocking
    // assignments. A flip of holdoff_toggle asks for one long hold-off.
    logic rx_idle_on     = 1'b1;
    logic holdoff_toggle = 1'b0;

    // Predicted result beats, oldest first.
    assoc_result_t pending_results [$];

    int mismatches      = 0;
    int cycles          = 0;
    int events_accepted = 0;
    int results_checked = 0;
    int invalid_results = 0;
    int collisions_req  = 0;
    int collisions_acc  = 0;
    int input_blocked   = 0;
    logic [15:0] states_seen = '0;

    // Random idle length: most gaps are short, a few are long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Timeout. A stuck handshake anywhere ends the run here.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It stalls the result channel in random bursts, stays quiet
    // while rx_idle_on is low, and on request holds off for a long stretch
    // that it counts itself.
    // ------------------------------------------------------------------
    logic holdoff_seen = 1'b0;
    int   rx_stall_left = 0;
    int   rx_run_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_seen = holdoff_toggle;
            rx_stall_left = 0;
            rx_run_left = 0;
            i_out_stall <= 1'b0;
        end else if (holdoff_toggle != holdoff_seen) begin
            holdoff_seen = holdoff_toggle;
            rx_stall_left = HOLDOFF_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_idle_on) begin
            i_out_stall <= 1'b0;
        end else if (rx_run_left > 0) begin
            rx_run_left--;
            i_out_stall <= 1'b0;
        end else begin
            // Start a new burst: this cycle is open, then the stall, then a
            // short run of open cycles.
            rx_stall_left = pick_gap();
            rx_run_left = $urandom_range(0, 10);
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Predictor and checker. At every edge the accepted event beat is run
    // through the predictor, whose own copy of the connection state and the
    // role register follows the block, and each accepted result beat is
    // compared with the oldest prediction.
    // ------------------------------------------------------------------
    logic [ST_W-1:0] model_state = STA1;
    logic            model_role  = RL_REQUESTOR;
    assoc_result_t   predicted;
    assoc_result_t   oldest;

    task automatic check_field(input string name, input logic [ST_W-1:0] want,
                               input logic [ST_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_state = STA1;
            model_role = RL_REQUESTOR;
        end else begin
            if (i_cfg_we) begin
                model_role = i_cfg_wdata;
            end
            if (i_in_valid && o_in_stall) begin
                input_blocked++;
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = assoc_step(model_state, model_role, i_event_code);
                if (model_state == STA7 && i_event_code == EV_REL_RQ_PDU) begin
                    if (model_role) collisions_req++;
                    else collisions_acc++;
                end
                model_state = predicted.conn_state;
                states_seen[model_state] = 1'b1;
                events_accepted++;
                pending_results.push_back(beat_pinned ? beat_want : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no event waiting for it (state %0d)",
                           o_conn_state_now);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    results_checked++;
                    if (oldest.invalid_ev) invalid_results++;
                    check_field("conn_state_now", oldest.conn_state, o_conn_state_now);
                    check_field("invalid_event", oldest.invalid_ev, o_invalid_event);
                    check_field("send_abort", oldest.send_abort, o_send_abort);
                    check_field("timer_start", oldest.timer_start, o_timer_start);
                    check_field("timer_stop", oldest.timer_stop, o_timer_stop);
                    check_field("close_transport", oldest.close_tp, o_close_transport);
                    check_field("skip_next_pdu", oldest.skip_pdu, o_skip_next_pdu);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. It keeps its own view of the connection state so that most
    // random events carry the association forward instead of bouncing off
    // the table at idle.
    // ------------------------------------------------------------------
    logic [ST_W-1:0] drv_state = STA1;
    logic            drv_role  = RL_REQUESTOR;

    // Chooses the next event: half the time the one that moves a healthy
    // association along, then any allowed event, then any table event, and
    // now and then a code past the last event.
    function automatic logic [EV_W-1:0] pick_event(input logic [ST_W-1:0] cur);
        logic [EV_W-1:0] ev;
        int roll;
        int tries;
        roll = $urandom_range(0, 99);
        ev = $urandom_range(0, EV_LAST);
        if (roll < 50) begin
            case (cur)
                STA1:  ev = $urandom_range(0, 1) ? EV_LOCAL_ASSOC_RQ : EV_TRANSPORT_IND;
                STA2:  ev = EV_ASSOC_RQ_PDU;
                STA3:  ev = ($urandom_range(0, 4) != 0) ? EV_LOCAL_ASSOC_AC
                                                        : EV_LOCAL_ASSOC_RJ;
                STA4:  ev = EV_TRANSPORT_CONF;
                STA5:  ev = ($urandom_range(0, 4) != 0) ? EV_ASSOC_AC_PDU
                                                        : EV_ASSOC_RJ_PDU;
                STA6: begin
                    case ($urandom_range(0, 3))
                        0:       ev = EV_LOCAL_DATA;
                        1:       ev = EV_DATA_PDU;
                        2:       ev = EV_LOCAL_REL_RQ;
                        default: ev = EV_REL_RQ_PDU;
                    endcase
                end
                STA7: begin
                    case ($urandom_range(0, 2))
                        0:       ev = EV_REL_RQ_PDU;
                        1:       ev = EV_REL_RP_PDU;
                        default: ev = EV_DATA_PDU;
                    endcase
                end
                STA8:  ev = $urandom_range(0, 1) ? EV_LOCAL_DATA : EV_LOCAL_REL_RP;
                STA9:  ev = EV_LOCAL_REL_RP;
                STA10: ev = EV_REL_RP_PDU;
                STA11: ev = EV_REL_RP_PDU;
                STA12: ev = EV_LOCAL_REL_RP;
                STA13: begin
                    case ($urandom_range(0, 2))
                        0:       ev = EV_TRANSPORT_CLOSED;
                        1:       ev = EV_ABORT_PDU;
                        default: ev = EV_TIMER_EXPIRED;
                    endcase
                end
                default: ;
            endcase
        end else if (roll < 80) begin
            tries = 0;
            while (ACTION_MAP[ev][cur] == ILL && tries < 32) begin
                ev = $urandom_range(0, EV_LAST);
                tries++;
            end
        end else if (roll >= 95) begin
            ev = $urandom_range(EV_LAST + 1, EV_CODE_MAX);
        end
        return ev;
    endfunction

    // Offers one event beat and returns at the edge that accepts it. Valid
    // stays high so that the caller can chain the next beat without a gap.
    task automatic offer_beat(input logic [EV_W-1:0] ev, input logic pinned,
                              input assoc_result_t want);
        i_in_valid <= 1'b1;
        i_event_code <= ev;
        beat_pinned <= pinned;
        beat_want <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        drv_state = assoc_step(drv_state, drv_role, ev).conn_state;
    endtask

    // Idles the sender for a number of cycles, with junk on the event bus.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            i_event_code <= $urandom_range(0, EV_CODE_MAX);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Holds the sender back until every predicted result has come out,
    // then lets the pipeline settle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Writes the role register; only called while the block is idle.
    task automatic write_role(input logic role);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= role;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        drv_role = role;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    //   1. Hold reset, then release it.
    //   2. Directed table with the role at its reset value (requestor).
    //   3. Four random phases (0..3), alternating acceptor and requestor.
    //      Each contains a stretch with no idling on either side. Phases 1 and 3
    //      add a long receiver hold-off while the sender offers back to back,
    //      so that the queue fills and the input stalls. Phase 2 contains a
    //      sender pause until every expected result has come.
    // ------------------------------------------------------------------
    initial begin
        int i;
        int ph;
        logic quiet;
        logic rush;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            offer_beat(DIRECTED[i].ev, DIRECTED[i].pinned, DIRECTED[i].want);
            idle_sender(pick_gap());
        end
        drain_results();

        for (ph = 0; ph < N_PHASES; ph++) begin
            write_role((ph % 2 == 0) ? RL_ACCEPTOR : RL_REQUESTOR);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                quiet = (i >= 100 && i < 160);
                rush = (ph % 2 == 1) && (i >= 200 && i < 240);
                if (i == 100) rx_idle_on <= 1'b0;
                if (i == 160) rx_idle_on <= 1'b1;
                if (ph % 2 == 1 && i == 200) holdoff_toggle <= ~holdoff_toggle;
                if (ph == 2 && i == 180) drain_results();
                offer_beat(pick_event(drv_state), 1'b0, NOT_PINNED);
                if (!quiet && !rush) idle_sender(pick_gap());
            end
            drain_results();
        end

        $display("Checked %0d result beats for %0d event beats; %0d were invalid events.",
                 results_checked, events_accepted, invalid_results);
        $display("States reached mask %b, collisions %0d as requestor and %0d as acceptor, %0d input-stalled cycles.",
                 states_seen[13:1], collisions_req, collisions_acc, input_blocked);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/aulf_pkg.sv
rtl/core/aulf_front.sv
rtl/core/aulf_queue.sv
rtl/core/aulf_back.sv
rtl/core/assoc_upper_layer_fsm.sv
rtl/core/aulf_checker.sv
bench/assoc_upper_layer_fsm_tb.sv
